@@ rtl/core/qrgs_pkg.sv @@
// Shared constants and types for the Gram-Schmidt QR block.
// No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package qrgs_pkg;

    localparam int VAL_W = 32;          // Q-format element width
    localparam int SQ_W  = 64;          // sum-of-squares width

    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_MAX_COLS  = 4;
    localparam int DEF_FRAC_BITS = 16;

    localparam int ROW_W = 4;           // rows_in_use register width
    localparam int COL_W = 3;           // cols_in_use register width

    localparam logic [ROW_W-1:0] ROWS_RESET = 4'd4;
    localparam logic [COL_W-1:0] COLS_RESET = 3'd4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    localparam int TDATA_W = 40;        // value, row, col, pad
    localparam int TUSER_W = 2;         // from_r, status

    typedef logic signed [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

@@ rtl/core/qr_gram_schmidt_decomposition.sv @@
// Top level: modified Gram-Schmidt QR over a column store and a work memory.
// Depends on qrgs_pkg, qrgs_sqrt, qrgs_div.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata element_value, s_tlast last
//  m_      | out | m_tvalid/m_tready  | m_tdata value,row,col; m_tuser; m_tlast
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Loading takes one element per cycle. The last element starts the solve:
// each element is copied to the work memory, each column norm takes a
// sum-of-squares pass and the square root, and each column is normalized in
// the bit-serial divider, which dominates; each projection adds a dot product
// and an update pass. A new output transaction can be loaded as the previous
// one is taken, and each is held while m_tready is low. Reset is synchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module qr_gram_schmidt_decomposition #(
    parameter int MAX_ROWS  = qrgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = qrgs_pkg::DEF_MAX_COLS,
    parameter int FRAC_BITS = qrgs_pkg::DEF_FRAC_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [qrgs_pkg::VAL_W-1:0]       s_tdata,   // [31:0] element_value
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [31:0] value, [34:32] row_index, [36:35] col_index, [39:37] zero
    output logic [qrgs_pkg::TDATA_W-1:0]          m_tdata,
    output logic [qrgs_pkg::TUSER_W-1:0]          m_tuser,   // [0] from_r, [1] status
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [qrgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [qrgs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int VW    = qrgs_pkg::VAL_W;
    localparam int ROW_W = qrgs_pkg::ROW_W;
    localparam int COL_W = qrgs_pkg::COL_W;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int RDEP  = MAX_COLS * MAX_COLS;
    localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;
    localparam int QIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_COPY_RD   = 5'd1;
    localparam logic [4:0] ST_COPY_WR   = 5'd2;
    localparam logic [4:0] ST_SS_RD     = 5'd3;
    localparam logic [4:0] ST_SS_MUL    = 5'd4;
    localparam logic [4:0] ST_SS_ACC    = 5'd5;
    localparam logic [4:0] ST_SQ_GO     = 5'd6;
    localparam logic [4:0] ST_SQ_WAIT   = 5'd7;
    localparam logic [4:0] ST_NRM_RD    = 5'd8;
    localparam logic [4:0] ST_NRM_GO    = 5'd9;
    localparam logic [4:0] ST_NRM_WAIT  = 5'd10;
    localparam logic [4:0] ST_DOT_START = 5'd11;
    localparam logic [4:0] ST_DOT_RD    = 5'd12;
    localparam logic [4:0] ST_DOT_MUL   = 5'd13;
    localparam logic [4:0] ST_DOT_ACC   = 5'd14;
    localparam logic [4:0] ST_DOT_R     = 5'd15;
    localparam logic [4:0] ST_UPD_RD    = 5'd16;
    localparam logic [4:0] ST_UPD_MUL   = 5'd17;
    localparam logic [4:0] ST_UPD_RND   = 5'd18;
    localparam logic [4:0] ST_UPD_WR    = 5'd19;
    localparam logic [4:0] ST_NEXT_K    = 5'd20;
    localparam logic [4:0] ST_OUT_RD    = 5'd21;
    localparam logic [4:0] ST_OUT_Q     = 5'd22;
    localparam logic [4:0] ST_OUT_R     = 5'd23;
    localparam logic [4:0] ST_ERR       = 5'd24;

    function automatic logic [AW-1:0] waddr(input logic [COL_W-1:0] c,
                                            input logic [ROW_W-1:0] r);
        waddr = AW'(int'(c) * MAX_ROWS + int'(r));
    endfunction

    function automatic logic [RAW-1:0] ridx(input logic [COL_W-1:0] c,
                                            input logic [COL_W-1:0] r);
        ridx = RAW'(int'(c) * MAX_COLS + int'(r));
    endfunction

    // shift right by FRAC_BITS, round half away from zero, clamp to 32 bits
    function automatic logic [31:0] rnd_sat(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [64:0] sum;
        logic [64:0] m;
        mag = v[63] ? (~v + 64'd1) : v;
        sum = {1'b0, mag} + (65'd1 << (FRAC_BITS - 1));
        m   = sum >> FRAC_BITS;
        if (!v[63]) begin
            rnd_sat = (|m[64:31]) ? 32'h7FFF_FFFF : m[31:0];
        end else if ((|m[64:32]) || (m[31] && |m[30:0])) begin
            rnd_sat = 32'h8000_0000;
        end else begin
            rnd_sat = ~m[31:0] + 32'd1;
        end
    endfunction

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            add_sat64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            add_sat64 = s[63:0];
        end
    endfunction

    function automatic logic [31:0] sub_sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            sub_sat32 = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sub_sat32 = d[31:0];
        end
    endfunction

    // configuration
    logic [ROW_W-1:0] rows_reg;
    logic [COL_W-1:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= qrgs_pkg::ROWS_RESET;
            cols_reg <= qrgs_pkg::COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                qrgs_pkg::REG_ROWS: rows_reg <= cfg_wdata[ROW_W-1:0];
                qrgs_pkg::REG_COLS: cols_reg <= cfg_wdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // state and datapath registers
    logic [4:0]       state_reg, state_next;
    logic [COL_W-1:0] k_reg, k_next;
    logic [COL_W-1:0] j_reg, j_next;
    logic [ROW_W-1:0] i_reg, i_next;
    logic [LCW-1:0]   src_reg, src_next;
    logic [LCW-1:0]   load_cnt_reg, load_cnt_next;
    logic [63:0]      ss_reg, ss_next;
    logic [63:0]      dot_reg, dot_next;
    logic [VW-1:0]    nrm_reg, nrm_next;
    logic [VW-1:0]    r_reg, r_next;
    logic [VW-1:0]    aj_reg, aj_next;
    logic [VW-1:0]    p_reg, p_next;
    logic signed [63:0] mul_reg, mul_next;

    logic             mo_valid_reg, mo_valid_next;
    logic [VW-1:0]    mo_value_reg, mo_value_next;
    logic             mo_from_r_reg, mo_from_r_next;
    logic [2:0]       mo_row_reg, mo_row_next;
    logic [1:0]       mo_col_reg, mo_col_next;
    logic             mo_status_reg, mo_status_next;
    logic             mo_last_reg, mo_last_next;

    // memories and small register files
    logic [VW-1:0] cs_mem [DEPTH];
    logic [VW-1:0] cs_rdata_reg;
    logic [VW-1:0] wm_mem [DEPTH];
    logic [VW-1:0] wm_rdata_reg;
    logic [VW-1:0] rs_reg [RDEP];
    logic [VW-1:0] qcol_reg [MAX_ROWS];

    logic           s_accept;
    logic           cs_we;
    logic           wm_we;
    logic [AW-1:0]  wm_waddr;
    logic [AW-1:0]  wm_raddr;
    logic [VW-1:0]  wm_wdata;
    logic           rs_we;
    logic           rs_clr;
    logic [RAW-1:0] rs_widx;
    logic [VW-1:0]  rs_wdata;
    logic           qc_we;
    logic           can_load;
    logic           bad_shape;
    logic           sq_start, sq_done;
    logic [VW-1:0]  sq_root;
    logic           dv_start, dv_done;
    qrgs_pkg::val_t dv_quot;
    logic signed [VW-1:0] mul_a, mul_b;
    logic [64:0]    ss_sum;
    logic [VW-1:0]  nrm_val;
    logic [VW-1:0]  r_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign can_load = !mo_valid_reg || m_tready;
    assign bad_shape = (cols_reg == '0) || (rows_reg < {1'b0, cols_reg})
                    || (int'(rows_reg) > MAX_ROWS) || (int'(cols_reg) > MAX_COLS);
    assign cs_we = s_accept && (int'(load_cnt_reg) < DEPTH);

    // projection reads go to column j, everything else to column k
    assign wm_raddr = (state_reg == ST_DOT_RD || state_reg == ST_UPD_RD)
                    ? waddr(j_reg, i_reg) : waddr(k_reg, i_reg);

    assign mul_a   = (state_reg == ST_SS_MUL) ? wm_rdata_reg : qcol_reg[i_reg[QIW-1:0]];
    assign mul_b   = (state_reg == ST_UPD_MUL) ? r_reg : wm_rdata_reg;
    assign ss_sum  = {1'b0, ss_reg} + {1'b0, mul_reg};
    assign nrm_val = sq_root[VW-1] ? 32'h7FFF_FFFF : sq_root;
    assign r_val   = rnd_sat(dot_reg);

    qrgs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (ss_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    qrgs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .x       (wm_rdata_reg),
        .den     (nrm_reg),
        .done    (dv_done),
        .quot    (dv_quot)
    );

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        src_next       = src_reg;
        load_cnt_next  = load_cnt_reg;
        ss_next        = ss_reg;
        dot_next       = dot_reg;
        nrm_next       = nrm_reg;
        r_next         = r_reg;
        aj_next        = aj_reg;
        p_next         = p_reg;
        mul_next       = mul_a * mul_b;
        mo_valid_next  = mo_valid_reg && !m_tready;
        mo_value_next  = mo_value_reg;
        mo_from_r_next = mo_from_r_reg;
        mo_row_next    = mo_row_reg;
        mo_col_next    = mo_col_reg;
        mo_status_next = mo_status_reg;
        mo_last_next   = mo_last_reg;
        wm_we          = 1'b0;
        wm_waddr       = waddr(k_reg, i_reg);
        wm_wdata       = cs_rdata_reg;
        rs_we          = 1'b0;
        rs_clr         = 1'b0;
        rs_widx        = ridx(k_reg, k_reg);
        rs_wdata       = nrm_val;
        qc_we          = 1'b0;
        sq_start       = 1'b0;
        dv_start       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (cs_we) begin
                        load_cnt_next = load_cnt_reg + LCW'(1);
                    end
                    if (s_tlast) begin
                        load_cnt_next = '0;
                        k_next   = '0;
                        i_next   = '0;
                        src_next = '0;
                        rs_clr   = 1'b1;
                        state_next = bad_shape ? ST_ERR : ST_COPY_RD;
                    end
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                wm_we    = 1'b1;
                src_next = src_reg + LCW'(1);
                state_next = ST_COPY_RD;
                if (i_reg == rows_reg - ROW_W'(1)) begin
                    i_next = '0;
                    if (k_reg == cols_reg - COL_W'(1)) begin
                        k_next  = '0;
                        ss_next = '0;
                        state_next = ST_SS_RD;
                    end else begin
                        k_next = k_reg + COL_W'(1);
                    end
                end else begin
                    i_next = i_reg + ROW_W'(1);
                end
            end
            ST_SS_RD:  state_next = ST_SS_MUL;
            ST_SS_MUL: state_next = ST_SS_ACC;
            ST_SS_ACC: begin
                ss_next = ss_sum[64] ? {64{1'b1}} : ss_sum[63:0];
                if (i_reg == rows_reg - ROW_W'(1)) begin
                    i_next = '0;
                    state_next = ST_SQ_GO;
                end else begin
                    i_next = i_reg + ROW_W'(1);
                    state_next = ST_SS_RD;
                end
            end
            ST_SQ_GO: begin
                sq_start   = 1'b1;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    if (nrm_val == '0) begin
                        // zero column: left as is, its row of R stays zero
                        state_next = ST_NEXT_K;
                    end else begin
                        rs_we    = 1'b1;
                        nrm_next = nrm_val;
                        state_next = ST_NRM_RD;
                    end
                end
            end
            ST_NRM_RD: state_next = ST_NRM_GO;
            ST_NRM_GO: begin
                dv_start   = 1'b1;
                state_next = ST_NRM_WAIT;
            end
            ST_NRM_WAIT: begin
                if (dv_done) begin
                    wm_we    = 1'b1;
                    wm_wdata = dv_quot;
                    qc_we    = 1'b1;
                    if (i_reg == rows_reg - ROW_W'(1)) begin
                        i_next = '0;
                        j_next = k_reg + COL_W'(1);
                        state_next = ST_DOT_START;
                    end else begin
                        i_next = i_reg + ROW_W'(1);
                        state_next = ST_NRM_RD;
                    end
                end
            end
            ST_DOT_START: begin
                dot_next = '0;
                i_next   = '0;
                state_next = (j_reg >= cols_reg) ? ST_NEXT_K : ST_DOT_RD;
            end
            ST_DOT_RD:  state_next = ST_DOT_MUL;
            ST_DOT_MUL: state_next = ST_DOT_ACC;
            ST_DOT_ACC: begin
                dot_next = add_sat64(dot_reg, mul_reg);
                if (i_reg == rows_reg - ROW_W'(1)) begin
                    i_next = '0;
                    state_next = ST_DOT_R;
                end else begin
                    i_next = i_reg + ROW_W'(1);
                    state_next = ST_DOT_RD;
                end
            end
            ST_DOT_R: begin
                rs_we    = 1'b1;
                rs_widx  = ridx(j_reg, k_reg);
                rs_wdata = r_val;
                r_next   = r_val;
                state_next = ST_UPD_RD;
            end
            // read, then write back the same entry before the next read
            ST_UPD_RD: state_next = ST_UPD_MUL;
            ST_UPD_MUL: begin
                aj_next    = wm_rdata_reg;
                state_next = ST_UPD_RND;
            end
            ST_UPD_RND: begin
                p_next     = rnd_sat(mul_reg);
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                wm_we    = 1'b1;
                wm_waddr = waddr(j_reg, i_reg);
                wm_wdata = sub_sat32(aj_reg, p_reg);
                if (i_reg == rows_reg - ROW_W'(1)) begin
                    i_next = '0;
                    j_next = j_reg + COL_W'(1);
                    state_next = ST_DOT_START;
                end else begin
                    i_next = i_reg + ROW_W'(1);
                    state_next = ST_UPD_RD;
                end
            end
            ST_NEXT_K: begin
                i_next  = '0;
                ss_next = '0;
                if (k_reg == cols_reg - COL_W'(1)) begin
                    k_next = '0;
                    state_next = ST_OUT_RD;
                end else begin
                    k_next = k_reg + COL_W'(1);
                    state_next = ST_SS_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_Q;
            ST_OUT_Q: begin
                if (can_load) begin
                    mo_valid_next  = 1'b1;
                    mo_value_next  = wm_rdata_reg;
                    mo_from_r_next = 1'b0;
                    mo_row_next    = i_reg[2:0];
                    mo_col_next    = k_reg[1:0];
                    mo_status_next = 1'b0;
                    mo_last_next   = 1'b0;
                    state_next     = ST_OUT_RD;
                    if (i_reg == rows_reg - ROW_W'(1)) begin
                        i_next = '0;
                        if (k_reg == cols_reg - COL_W'(1)) begin
                            k_next = '0;
                            state_next = ST_OUT_R;
                        end else begin
                            k_next = k_reg + COL_W'(1);
                        end
                    end else begin
                        i_next = i_reg + ROW_W'(1);
                    end
                end
            end
            ST_OUT_R: begin
                if (can_load) begin
                    mo_valid_next  = 1'b1;
                    mo_value_next  = rs_reg[ridx(k_reg, i_reg[COL_W-1:0])];
                    mo_from_r_next = 1'b1;
                    mo_row_next    = i_reg[2:0];
                    mo_col_next    = k_reg[1:0];
                    mo_status_next = 1'b0;
                    mo_last_next   = 1'b0;
                    if (i_reg == {1'b0, cols_reg} - ROW_W'(1)) begin
                        i_next = '0;
                        if (k_reg == cols_reg - COL_W'(1)) begin
                            k_next       = '0;
                            mo_last_next = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            k_next = k_reg + COL_W'(1);
                        end
                    end else begin
                        i_next = i_reg + ROW_W'(1);
                    end
                end
            end
            ST_ERR: begin
                if (can_load) begin
                    mo_valid_next  = 1'b1;
                    mo_value_next  = '0;
                    mo_from_r_next = 1'b0;
                    mo_row_next    = '0;
                    mo_col_next    = '0;
                    mo_status_next = 1'b1;
                    mo_last_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            load_cnt_reg <= '0;
            mo_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            mo_valid_reg <= mo_valid_next;
        end
        k_reg          <= k_next;
        j_reg          <= j_next;
        i_reg          <= i_next;
        src_reg        <= src_next;
        ss_reg         <= ss_next;
        dot_reg        <= dot_next;
        nrm_reg        <= nrm_next;
        r_reg          <= r_next;
        aj_reg         <= aj_next;
        p_reg          <= p_next;
        mul_reg        <= mul_next;
        mo_value_reg   <= mo_value_next;
        mo_from_r_reg  <= mo_from_r_next;
        mo_row_reg     <= mo_row_next;
        mo_col_reg     <= mo_col_next;
        mo_status_reg  <= mo_status_next;
        mo_last_reg    <= mo_last_next;
    end

    // column store: element n of the stream at entry n
    always_ff @(posedge aclk) begin
        if (cs_we) begin
            cs_mem[load_cnt_reg[AW-1:0]] <= s_tdata;
        end
        cs_rdata_reg <= cs_mem[src_reg[AW-1:0]];
    end

    // work memory: column k at entries k*MAX_ROWS ..
    always_ff @(posedge aclk) begin
        if (wm_we) begin
            wm_mem[wm_waddr] <= wm_wdata;
        end
        wm_rdata_reg <= wm_mem[wm_raddr];
    end

    // R, stored column-major, cleared at the start of each solve
    always_ff @(posedge aclk) begin
        if (!aresetn || rs_clr) begin
            for (int n = 0; n < RDEP; n++) begin
                rs_reg[n] <= '0;
            end
        end else if (rs_we) begin
            rs_reg[rs_widx] <= rs_wdata;
        end
    end

    // copy of the normalized column k for dot products and updates
    always_ff @(posedge aclk) begin
        if (qc_we) begin
            qcol_reg[i_reg[QIW-1:0]] <= dv_quot;
        end
    end

    assign m_tvalid = mo_valid_reg;
    assign m_tdata  = {3'b000, mo_col_reg, mo_row_reg, mo_value_reg};
    assign m_tuser  = {mo_status_reg, mo_from_r_reg};
    assign m_tlast  = mo_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/qrgs_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on qrgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrgs_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [qrgs_pkg::SQ_W-1:0]  radicand,
    output logic                            done,
    output logic [qrgs_pkg::VAL_W-1:0]      root
);

    localparam int W = qrgs_pkg::SQ_W;

    logic [W-1:0] s_reg, s_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] trial;

    always_comb begin
        s_next    = s_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start) begin
            s_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(W-2){1'b0}}};
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (s_reg >= trial) begin
                s_next   = s_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_next == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        s_reg   <= s_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[qrgs_pkg::VAL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/qrgs_div.sv @@
// Bit-serial restoring divider: round((|x| << FRAC_BITS) / den), signed, saturated.
// Depends on qrgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrgs_div #(
    parameter int FRAC_BITS = qrgs_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire qrgs_pkg::val_t              x,
    input  wire logic [qrgs_pkg::VAL_W-1:0]  den,
    output logic                             done,
    output qrgs_pkg::val_t                   quot
);

    localparam int VW = qrgs_pkg::VAL_W;
    localparam int NQ = VW + FRAC_BITS + 1;
    localparam int CW = $clog2(NQ + 1);

    logic [NQ-1:0] num_reg, num_next;
    logic [NQ-1:0] q_reg, q_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW-1:0] mag;
    logic [VW:0]   rem_sh;
    logic          ge;

    always_comb begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag       = x[VW-1] ? (~x + VW'(1)) : x;
        rem_sh    = {rem_reg[VW-1:0], num_reg[NQ-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        if (start) begin
            // numerator carries the half-divisor bias for round-to-nearest
            num_next  = {1'b0, mag, {FRAC_BITS{1'b0}}} + NQ'(den >> 1);
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            neg_next  = x[VW-1];
            cnt_next  = CW'(NQ);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_next   = {q_reg[NQ-2:0], ge};
            num_next = {num_reg[NQ-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        if (!neg_reg) begin
            quot = (|q_reg[NQ-1:VW-1]) ? 32'sh7FFF_FFFF : q_reg[VW-1:0];
        end else if ((|q_reg[NQ-1:VW]) || (q_reg[VW-1] && |q_reg[VW-2:0])) begin
            quot = 32'sh8000_0000;
        end else begin
            quot = ~q_reg[VW-1:0] + VW'(1);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/core/qrgs_checker.sv @@
// Port-level checks for the Gram-Schmidt QR top level, bound to every instance.
// Depends on qrgs_pkg and qr_gram_schmidt_decomposition.
`timescale 1ns / 1ps
`default_nettype none

module qrgs_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             s_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [qrgs_pkg::TDATA_W-1:0]     m_tdata,
    input wire logic [qrgs_pkg::TUSER_W-1:0]     m_tuser,
    input wire logic                             m_tlast
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a shape error is a lone, all-zero transaction
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata == '0))
        else $error("malformed error result");

    // no new matrix is taken while a result stream is mid-flight
    a_no_load_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during result stream");

    // input side stays open past the final transaction unless a last element starts a solve
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tready && s_tready && !(s_tvalid && s_tlast)
        |=> s_tready)
        else $error("input not ready after final result");

endmodule

bind qr_gram_schmidt_decomposition qrgs_checker u_qrgs_checker (.*);

`default_nettype wire
